@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the float32 to decimal text block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ sv/f2t_pkg.sv @@
// Package for the float32 to decimal text block: types, codes, constants.
// No dependencies.
package f2t_pkg;

    localparam int FracDigitsDef = 6;
    localparam int IntDigits     = 10;
    localparam int IntW          = 32;
    localparam int MantW         = 23;
    localparam int SigW          = 24;
    localparam int LenW          = 5;
    localparam logic [7:0] ExpAllOnes = 8'd255;
    localparam logic [7:0] ExpBias    = 8'd127;
    localparam logic [7:0] ExpTooBig  = 8'd159;
    localparam logic [7:0] CapReset   = 8'd20;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_ROOM   = 2'd1,
        STAT_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_INF, KIND_NAN, KIND_ZERO, KIND_NUM, KIND_BIG
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SHIFT, ST_CONV, ST_COUNT, ST_CHECK, ST_EMIT
    } state_t;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

@@ sv/float32_to_decimal_text_top.sv @@
// Sequence: specials go from accept to the length check, then emit; finite numbers
// multiply, shift, run the bits through the BCD cell rows, count digits, check length.
// Output: one character beat per cycle while the receiver keeps m_ready high, one word
// at a time: no new word is accepted until the last beat of the current word is issued.
// Reset (aresetn low, synchronous): idle, no output beat, capacity 20.
// Depends on f2t_pkg, f2t_bcd_chain, f2t_bcd_cell and assert_macros.svh.
`include "assert_macros.svh"
module float32_to_decimal_text_top #(
    parameter int FRACTION_DIGITS = f2t_pkg::FracDigitsDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_float_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_char,
    output logic        m_last_char,
    output logic [1:0]  m_status
);
    localparam logic [63:0] Pow10 = f2t_pkg::pow10(FRACTION_DIGITS);
    localparam int P10W  = $clog2(Pow10 + 64'd1);
    localparam int ProdW = f2t_pkg::SigW + P10W;
    localparam int FIdxW = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam int LenW  = f2t_pkg::LenW;
    localparam int IntW  = f2t_pkg::IntW;

    f2t_pkg::state_t  state_reg, state_next;
    f2t_pkg::kind_t   kind_reg;
    f2t_pkg::status_t stat_reg, stat_next;
    logic             neg_reg;
    logic [IntW-1:0]  int_sh_reg;
    logic [IntW-1:0]  frac_sh_reg;
    logic [f2t_pkg::SigW-1:0] fnum_reg;
    logic [7:0]       fshift_reg;
    logic [ProdW-1:0] prod_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic [3:0]       nd_reg, nd_next;
    logic [LenW-1:0]  len_reg, len_next;
    logic [LenW-1:0]  pos_reg, pos_next;
    logic [7:0]       cap_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_text_char_reg, m_text_char_next;
    logic             m_last_char_reg, m_last_char_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic [3:0] int_dig  [f2t_pkg::IntDigits];
    logic [3:0] frac_dig [FRACTION_DIGITS];

    logic             accept;
    logic             slot_free;
    logic [22:0]      in_mant;
    logic [7:0]       in_expo;
    logic [f2t_pkg::SigW-1:0] in_sig;
    logic [54:0]      scaled;
    logic [ProdW-1:0] shifted;
    logic [LenW-1:0]  int_idx, frac_idx;
    logic [7:0]       ch;
    logic             out_stat_beat;
    logic             emit_text_beat;

    assign s_ready     = (state_reg == f2t_pkg::ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign slot_free   = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_char_reg;
    assign m_last_char = m_last_char_reg;
    assign m_status    = m_status_reg;

    assign in_mant = s_float_bits[22:0];
    assign in_expo = s_float_bits[30:23];
    assign in_sig  = {(in_expo != 8'd0), in_mant};
    assign scaled  = {31'd0, in_sig} << in_expo[4:0] - f2t_pkg::ExpBias[4:0];
    assign shifted = prod_reg >> fshift_reg;

    // capacity register: write it only while no word is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= f2t_pkg::CapReset;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Datapath: decode on accept, then multiply, scale down, feed the cell rows
    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg <= s_float_bits[31];
            if (in_expo == f2t_pkg::ExpAllOnes && in_mant == 23'd0) begin
                kind_reg <= f2t_pkg::KIND_INF;
            end else if (in_expo == f2t_pkg::ExpAllOnes) begin
                kind_reg <= f2t_pkg::KIND_NAN;
            end else if (in_expo == 8'd0 && in_mant == 23'd0) begin
                kind_reg <= f2t_pkg::KIND_ZERO;
            end else if (in_expo >= f2t_pkg::ExpTooBig) begin
                kind_reg <= f2t_pkg::KIND_BIG;
            end else begin
                kind_reg <= f2t_pkg::KIND_NUM;
            end
            if (in_expo >= f2t_pkg::ExpBias) begin
                int_sh_reg <= scaled[54:23];
                fnum_reg   <= {1'b0, scaled[22:0]};
                fshift_reg <= 8'd23;
            end else begin
                // negative exponent: all of it is fraction, shift further right
                int_sh_reg <= '0;
                fnum_reg   <= in_sig;
                fshift_reg <= 8'd23 + ((in_expo == 8'd0) ? 8'd126
                                                         : f2t_pkg::ExpBias - in_expo);
            end
        end else if (state_reg == f2t_pkg::ST_MUL) begin
            prod_reg <= ProdW'(fnum_reg) * ProdW'(Pow10[P10W-1:0]);
        end else if (state_reg == f2t_pkg::ST_SHIFT) begin
            frac_sh_reg <= IntW'(shifted[P10W-1:0]);
        end else if (state_reg == f2t_pkg::ST_CONV) begin
            // advance both bit streams, MSB first
            int_sh_reg  <= {int_sh_reg[IntW-2:0], 1'b0};
            frac_sh_reg <= {frac_sh_reg[IntW-2:0], 1'b0};
        end
    end

    f2t_bcd_chain #(.N(f2t_pkg::IntDigits)) u_int_chain (
        .aclk   (aclk),
        .clear  (state_reg == f2t_pkg::ST_SHIFT),
        .shift  (state_reg == f2t_pkg::ST_CONV),
        .bit_in (int_sh_reg[IntW-1]),
        .digits (int_dig)
    );

    f2t_bcd_chain #(.N(FRACTION_DIGITS)) u_frac_chain (
        .aclk   (aclk),
        .clear  (state_reg == f2t_pkg::ST_SHIFT),
        .shift  (state_reg == f2t_pkg::ST_CONV),
        .bit_in (frac_sh_reg[IntW-1]),
        .digits (frac_dig)
    );

    // Character at the current position
    assign int_idx  = LenW'(nd_reg) - pos_reg;
    assign frac_idx = LenW'(FRACTION_DIGITS) + LenW'(nd_reg) + LenW'(1) - pos_reg;

    always_comb begin
        ch = 8'h00;
        case (kind_reg)
            f2t_pkg::KIND_INF: begin
                case (pos_reg)
                    LenW'(0): ch = neg_reg ? "-" : "+";
                    LenW'(1): ch = "i";
                    LenW'(2): ch = "n";
                    default:  ch = "f";
                endcase
            end
            f2t_pkg::KIND_NAN: begin
                ch = (pos_reg == LenW'(1)) ? "a" : "N";
            end
            f2t_pkg::KIND_ZERO: begin
                ch = (pos_reg == LenW'(0)) ? (neg_reg ? "-" : "+") : "0";
            end
            f2t_pkg::KIND_NUM: begin
                if (pos_reg == LenW'(0)) begin
                    ch = neg_reg ? "-" : "+";
                end else if (pos_reg <= LenW'(nd_reg)) begin
                    ch = 8'h30 + {4'd0, int_dig[int_idx[3:0]]};
                end else if (pos_reg == LenW'(nd_reg) + LenW'(1)) begin
                    ch = ".";
                end else begin
                    ch = 8'h30 + {4'd0, frac_dig[frac_idx[FIdxW-1:0]]};
                end
            end
            default: ch = 8'h00;
        endcase
    end

    // Control: sequencer and output register
    always_comb begin
        state_next       = state_reg;
        stat_next        = stat_reg;
        cnt_next         = cnt_reg;
        nd_next          = nd_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_text_char_next = m_text_char_reg;
        m_last_char_next = m_last_char_reg;
        m_status_next    = m_status_reg;
        case (state_reg)
            f2t_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_expo == f2t_pkg::ExpAllOnes || in_expo >= f2t_pkg::ExpTooBig
                        || (in_expo == 8'd0 && in_mant == 23'd0)) begin
                        state_next = f2t_pkg::ST_CHECK;
                    end else begin
                        state_next = f2t_pkg::ST_MUL;
                    end
                end
            end
            f2t_pkg::ST_MUL:   state_next = f2t_pkg::ST_SHIFT;
            f2t_pkg::ST_SHIFT: begin
                cnt_next   = 5'd0;
                state_next = f2t_pkg::ST_CONV;
            end
            f2t_pkg::ST_CONV: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = f2t_pkg::ST_COUNT;
                end
            end
            f2t_pkg::ST_COUNT: begin
                // highest nonzero integer digit; at least one digit is printed
                nd_next = 4'd1;
                for (int i = 1; i < f2t_pkg::IntDigits; i++) begin
                    if (int_dig[i] != 4'd0) begin
                        nd_next = 4'(i + 1);
                    end
                end
                state_next = f2t_pkg::ST_CHECK;
            end
            f2t_pkg::ST_CHECK: begin
                case (kind_reg)
                    f2t_pkg::KIND_INF:  len_next = LenW'(4);
                    f2t_pkg::KIND_NAN:  len_next = LenW'(3);
                    f2t_pkg::KIND_ZERO: len_next = LenW'(2);
                    default: len_next = LenW'(2 + FRACTION_DIGITS) + LenW'(nd_reg);
                endcase
                if (kind_reg == f2t_pkg::KIND_BIG) begin
                    stat_next = f2t_pkg::STAT_TOO_LARGE;
                end else if (8'(len_next) >= cap_reg) begin
                    stat_next = f2t_pkg::STAT_NO_ROOM;
                end else begin
                    stat_next = f2t_pkg::STAT_OK;
                end
                pos_next   = '0;
                state_next = f2t_pkg::ST_EMIT;
            end
            f2t_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (stat_reg != f2t_pkg::STAT_OK) begin
                        // single status beat, no text
                        m_text_char_next = 8'h00;
                        m_last_char_next = 1'b1;
                        m_status_next    = stat_reg;
                        state_next       = f2t_pkg::ST_IDLE;
                    end else begin
                        m_text_char_next = ch;
                        m_last_char_next = (pos_reg == len_reg - LenW'(1));
                        m_status_next    = f2t_pkg::STAT_OK;
                        pos_next         = pos_reg + LenW'(1);
                        if (pos_reg == len_reg - LenW'(1)) begin
                            state_next = f2t_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = f2t_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= f2t_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            stat_reg    <= f2t_pkg::STAT_OK;
            cnt_reg     <= '0;
            nd_reg      <= 4'd1;
            len_reg     <= '0;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            stat_reg    <= stat_next;
            cnt_reg     <= cnt_next;
            nd_reg      <= nd_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_text_char_reg <= m_text_char_next;
        m_last_char_reg <= m_last_char_next;
        m_status_reg    <= m_status_next;
    end

    // Qualifiers for the checks below
    assign out_stat_beat  = m_valid && (m_status != f2t_pkg::STAT_OK);
    assign emit_text_beat = (state_reg == f2t_pkg::ST_EMIT) && (stat_reg == f2t_pkg::STAT_OK);

    `ASSERT_CLK(a_stat_last, aclk, aresetn, out_stat_beat |-> m_last_char)
    `ASSERT_CLK(a_stat_zero, aclk, aresetn, out_stat_beat |-> (m_text_char == 8'h00))
    `ASSERT_NEVER(a_emit_busy, aclk, aresetn, s_ready && state_reg == f2t_pkg::ST_EMIT)
    `ASSERT_CLK(a_pos_bound, aclk, aresetn, emit_text_beat |-> (pos_reg < len_reg))
endmodule

@@ sv/f2t_bcd_cell.sv @@
// One decimal digit cell of the shift-and-add-3 binary to BCD converter.
// Depends on nothing; chained by f2t_bcd_chain.
module f2t_bcd_cell (
    input  logic       aclk,
    input  logic       clear,
    input  logic       shift,
    input  logic       bit_in,
    output logic       carry_out,
    output logic [3:0] digit
);
    logic [3:0] digit_reg;
    logic [3:0] adj;

    // add 3 before doubling when the digit would overflow past 9
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge aclk) begin
        if (clear) begin
            digit_reg <= 4'd0;
        end else if (shift) begin
            digit_reg <= {adj[2:0], bit_in};
        end
    end
endmodule

@@ sv/f2t_bcd_chain.sv @@
// Row of BCD cells; one binary bit enters at cell 0 each shift cycle.
// Depends on f2t_bcd_cell.
module f2t_bcd_chain #(
    parameter int N = 10
) (
    input  logic       aclk,
    input  logic       clear,
    input  logic       shift,
    input  logic       bit_in,
    output logic [3:0] digits [N]
);
    logic [N:0] carry;

    assign carry[0] = bit_in;

    for (genvar i = 0; i < N; i++) begin : g_cell
        f2t_bcd_cell u_cell (
            .aclk      (aclk),
            .clear     (clear),
            .shift     (shift),
            .bit_in    (carry[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
        );
    end
endmodule

@@ tb/sv/float32_to_decimal_text_top_tb.sv @@
// Testbench for float32_to_decimal_text_top: float words in, decimal text beats out.
// Depends on f2t_pkg and the RTL of the block; self-checking, no files read.
module float32_to_decimal_text_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_DIGITS = f2t_pkg::FracDigitsDef;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] stat;
    } text_beat_t;

    // One row of the directed table: a word, and optionally one typed-in beat.
    typedef struct {
        logic [31:0] bits;
        bit          fixed;
        text_beat_t  beat;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_float_bits = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last_char;
    logic [1:0]  m_status;

    float32_to_decimal_text_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_float_bits(s_float_bits),
        .m_valid(m_valid), .m_ready(m_ready), .m_text_char(m_text_char),
        .m_last_char(m_last_char), .m_status(m_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Capacity mirror, expected beats and bookkeeping.
    logic [7:0]  capacity = f2t_pkg::CapReset;
    text_beat_t  expected_text[$];
    int          errors = 0;
    int          words_sent = 0;
    int          beats_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic text_beat_t status_beat(f2t_pkg::status_t code);
        text_beat_t b;
        b.ch = 8'd0; b.last = 1'b1; b.stat = code;
        return b;
    endfunction

    // Work out the text for one word and queue its beats.
    function automatic void predict_text(logic [31:0] bits);
        logic [22:0]  mant;
        logic [7:0]   expo;
        logic         neg;
        logic [7:0]   txt[$];
        logic [63:0]  sig, intpart, fnum, prod, frac, p10;
        int           ue, fshift, nd;
        logic [7:0]   digs[$];
        text_beat_t   b;
        mant = bits[22:0];
        expo = bits[30:23];
        neg  = bits[31];
        txt  = {};
        digs = {};
        if (expo == f2t_pkg::ExpAllOnes && mant == 0) begin
            txt = {neg ? "-" : "+", "i", "n", "f"};
        end else if (expo == f2t_pkg::ExpAllOnes) begin
            txt = {"N", "a", "N"};
        end else if (expo == 0 && mant == 0) begin
            txt = {neg ? "-" : "+", "0"};
        end else begin
            if (expo == 0) begin
                sig = {41'd0, mant};
                ue = -126;
            end else begin
                sig = {40'd0, 1'b1, mant};
                ue = int'(expo) - 127;
            end
            if (ue >= 32) begin
                expected_text.push_back(status_beat(f2t_pkg::STAT_TOO_LARGE));
                return;
            end
            if (ue >= 0) begin
                intpart = (sig << ue) >> 23;
                fnum = (sig << ue) & 64'h7F_FFFF;
                fshift = 23;
            end else begin
                intpart = 0;
                fnum = sig;
                fshift = 23 - ue;
            end
            p10 = 1;
            for (int k = 0; k < FRAC_DIGITS; k++) p10 = p10 * 10;
            prod = fnum * p10;
            frac = (fshift >= 64) ? 64'd0 : (prod >> fshift);
            txt.push_back(neg ? "-" : "+");
            nd = 0;
            do begin
                digs.push_front(8'h30 + 8'(intpart % 10));
                intpart = intpart / 10;
                nd++;
            end while (intpart != 0 && nd < 11);
            foreach (digs[i]) txt.push_back(digs[i]);
            txt.push_back(".");
            digs = {};
            for (int k = 0; k < FRAC_DIGITS; k++) begin
                digs.push_front(8'h30 + 8'(frac % 10));
                frac = frac / 10;
            end
            foreach (digs[i]) txt.push_back(digs[i]);
        end
        if (txt.size() >= int'(capacity)) begin
            expected_text.push_back(status_beat(f2t_pkg::STAT_NO_ROOM));
            return;
        end
        foreach (txt[i]) begin
            b.ch = txt[i];
            b.last = (i == txt.size() - 1);
            b.stat = f2t_pkg::STAT_OK;
            expected_text.push_back(b);
        end
    endfunction

    // Number of beats the last prediction pushed for a directed word.
    function automatic int predicted_len(logic [31:0] bits);
        if (bits[30:23] == f2t_pkg::ExpAllOnes) return (bits[22:0] == 0) ? 4 : 3;
        if (bits[30:0] == 0) return 2;
        return 1;
    endfunction

    // Check every output beat against the oldest expectation.
    always @(posedge aclk) begin
        text_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_text.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat char=%h last=%b status=%0d",
                         $time, m_text_char, m_last_char, m_status);
            end else begin
                want = expected_text.pop_front();
                if (m_text_char !== want.ch) begin
                    errors++;
                    $display("%0t: text_char expected %h actual %h",
                             $time, want.ch, m_text_char);
                end
                if (m_last_char !== want.last) begin
                    errors++;
                    $display("%0t: last_char expected %b actual %b",
                             $time, want.last, m_last_char);
                end
                if (m_status !== want.stat) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.stat, m_status);
                end
            end
        end
    end

    // Receiver stall; draw a new ready every cycle per the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Present one word and hold it until accepted; predict at acceptance.
    // Valid stays high after acceptance so the next word can follow at once.
    task automatic send_word(logic [31:0] bits);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_float_bits <= bits;
        do @(posedge aclk); while (!s_ready);
        predict_text(bits);
        words_sent++;
    endtask

    // Drop valid, drain pending beats, let the block settle, then write capacity.
    task automatic set_capacity(logic [7:0] value);
        s_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        capacity = value;
    endtask

    // Random word: mostly interesting exponents, some fully random noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: w[30:23] = 8'($urandom_range(158, 100));
            4:          w[30:23] = 8'($urandom_range(170, 150));
            5:          w[30:23] = 8'd0;
            6:          w[30:23] = f2t_pkg::ExpAllOnes;
            7:          w[22:0]  = 23'd0;
            default: ;
        endcase
        return w;
    endfunction

    stim_row_t directed[$];

    initial begin
        logic [7:0] phase_caps[4];
        phase_caps = '{8'd255, 8'd12, 8'd0, 8'd20};
        // Directed rows: extremes typed in where the first beat is obvious.
        directed = '{
            '{32'h7F80_0000, 1'b1, '{"+", 1'b0, f2t_pkg::STAT_OK}},   // +inf
            '{32'hFF80_0000, 1'b1, '{"-", 1'b0, f2t_pkg::STAT_OK}},   // -inf
            '{32'h7FC0_0000, 1'b1, '{"N", 1'b0, f2t_pkg::STAT_OK}},   // quiet NaN
            '{32'hFFFF_FFFF, 1'b1, '{"N", 1'b0, f2t_pkg::STAT_OK}},   // NaN, all ones
            '{32'h7F80_0001, 1'b1, '{"N", 1'b0, f2t_pkg::STAT_OK}},   // signaling NaN
            '{32'h0000_0000, 1'b1, '{"+", 1'b0, f2t_pkg::STAT_OK}},   // +0
            '{32'h8000_0000, 1'b1, '{"-", 1'b0, f2t_pkg::STAT_OK}},   // -0
            '{32'h4F80_0000, 1'b1, '{8'd0, 1'b1, f2t_pkg::STAT_TOO_LARGE}}, // 2^32
            '{32'h7F7F_FFFF, 1'b1, '{8'd0, 1'b1, f2t_pkg::STAT_TOO_LARGE}}, // max finite
            '{32'h4F7F_FFFF, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // just below 2^32
            '{32'h0000_0001, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // min subnormal
            '{32'h807F_FFFF, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // max subnormal
            '{32'h0080_0000, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // min normal
            '{32'h3F80_0000, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // 1.0
            '{32'hBF00_0000, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // -0.5
            '{32'h3C23_D70A, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // 0.01, leading zeros
            '{32'h3DCC_CCCD, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // 0.1, truncation
            '{32'h4B7F_FFFF, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // 2^24-1
            '{32'h4CAA_AAAA, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}},  // alternating bits
            '{32'h3355_5555, 1'b0, '{8'd0, 1'b0, f2t_pkg::STAT_OK}}
        };
        recv_stall_pct = 0;
        send_idle_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk at the reset capacity; typed rows check the predictor too.
        foreach (directed[i]) begin
            send_word(directed[i].bits);
            if (directed[i].fixed &&
                expected_text[expected_text.size() - predicted_len(directed[i].bits)]
                    !== directed[i].beat) begin
                errors++;
                $display("%0t: row %0d first beat expected %h predicted %h", $time, i,
                         directed[i].beat,
                         expected_text[expected_text.size() - predicted_len(directed[i].bits)]);
            end
        end

        // Random phases: idle patterns crossed with capacity settings.
        for (int ph = 0; ph < 4; ph++) begin
            set_capacity(phase_caps[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < 110; n++) begin
                if (ph == 3 && n == 55) set_capacity(8'($urandom_range(255, 0)));
                send_word(random_word());
            end
        end

        s_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Covered %0d words and %0d text beats over four idle/stall phases,",
                 words_sent, beats_seen);
        $display("capacity values 20, 255, 12, 0 and one random setting.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
